// ----- rtl/core/sialu_pkg.sv -----
// Shared types, operator codes and status codes for the signed integer ALU.
// No dependencies; every other file in rtl/core imports this package.
package sialu_pkg;

    // Operator characters as they arrive on the command field.
    localparam logic [7:0] CMD_ADD = 8'h2B;  // '+'
    localparam logic [7:0] CMD_SUB = 8'h2D;  // '-'
    localparam logic [7:0] CMD_MUL = 8'h2A;  // '*'
    localparam logic [7:0] CMD_DIV = 8'h2F;  // '/'
    localparam logic [7:0] CMD_MOD = 8'h25;  // '%'

    // Status codes returned with each result.
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_DIV_ZERO = 2'd1;
    localparam logic [1:0] ST_MOD_ZERO = 2'd2;
    localparam logic [1:0] ST_BAD_OP   = 2'd3;

    // Number of quotient bits, one per divider stage.
    localparam int DIV_STEPS = 32;

    // Decoded operation carried down the pipeline.
    typedef enum logic [2:0] {
        OP_ADD,
        OP_SUB,
        OP_MUL,
        OP_DIV,
        OP_MOD,
        OP_BAD
    } t_op_kind;

    // Input transaction payload.
    typedef struct packed {
        logic [7:0]         cmd;
        logic signed [31:0] operand_a;
        logic signed [31:0] operand_b;
    } t_alu_in;

    // Output transaction payload.
    typedef struct packed {
        logic signed [31:0] result;
        logic [1:0]         status;
    } t_alu_out;

    // Working state of one transaction between pipeline stages.
    typedef struct packed {
        t_op_kind    op;
        logic [1:0]  status;
        logic [31:0] arith;    // sum, difference or product magnitude
        logic        neg_q;    // operand signs differ
        logic        neg_r;    // dividend is negative
        logic [31:0] rem;      // partial remainder
        logic [31:0] quo;      // dividend bits shifting out, quotient bits in
        logic [31:0] divisor;  // divisor magnitude
    } t_pipe;

endpackage

// ----- rtl/core/sialu_decode.sv -----
// First pipeline stage: operator decode, status, add/subtract and magnitudes.
// Depends on sialu_pkg.
module sialu_decode
    import sialu_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_adv,
    input  logic    i_valid,
    input  t_alu_in i_data,
    output logic    o_valid,
    output t_pipe   o_pipe
);

    logic  r_valid;
    t_pipe r_pipe;
    t_pipe n_pipe;

    // Decode the command and prepare the operands for later stages.
    always_comb begin
        n_pipe         = '0;
        n_pipe.neg_r   = i_data.operand_a[31];
        n_pipe.neg_q   = i_data.operand_a[31] ^ i_data.operand_b[31];
        n_pipe.quo     = i_data.operand_a[31] ? (32'd0 - i_data.operand_a)
                                              : i_data.operand_a;
        n_pipe.divisor = i_data.operand_b[31] ? (32'd0 - i_data.operand_b)
                                              : i_data.operand_b;
        n_pipe.rem     = '0;
        n_pipe.status  = ST_OK;
        n_pipe.arith   = '0;
        case (i_data.cmd)
            CMD_ADD: begin
                n_pipe.op    = OP_ADD;
                n_pipe.arith = i_data.operand_a + i_data.operand_b;
            end
            CMD_SUB: begin
                n_pipe.op    = OP_SUB;
                n_pipe.arith = i_data.operand_a - i_data.operand_b;
            end
            CMD_MUL: begin
                n_pipe.op = OP_MUL;
            end
            CMD_DIV: begin
                n_pipe.op = OP_DIV;
                if (i_data.operand_b == 32'sd0) begin
                    n_pipe.status = ST_DIV_ZERO;
                end
            end
            CMD_MOD: begin
                n_pipe.op = OP_MOD;
                if (i_data.operand_b == 32'sd0) begin
                    n_pipe.status = ST_MOD_ZERO;
                end
            end
            default: begin
                n_pipe.op     = OP_BAD;
                n_pipe.status = ST_BAD_OP;
            end
        endcase
    end

    // Stage register; only the valid bit is reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_pipe <= n_pipe;
        end
    end

    assign o_valid = r_valid;
    assign o_pipe  = r_pipe;

endmodule

// ----- rtl/core/sialu_mul.sv -----
// Multiply stage: product of the operand magnitudes, low 32 bits kept.
// Depends on sialu_pkg.
module sialu_mul
    import sialu_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_adv,
    input  logic  i_valid,
    input  t_pipe i_pipe,
    output logic  o_valid,
    output t_pipe o_pipe
);

    logic        r_valid;
    t_pipe       r_pipe;
    t_pipe       n_pipe;
    logic [31:0] w_prod;

    // The sign is restored at the end, so the magnitudes are multiplied here.
    // Only the low half of the product is ever needed.
    assign w_prod = i_pipe.quo * i_pipe.divisor;

    always_comb begin
        n_pipe = i_pipe;
        if (i_pipe.op == OP_MUL) begin
            n_pipe.arith = w_prod;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_pipe <= n_pipe;
        end
    end

    assign o_valid = r_valid;
    assign o_pipe  = r_pipe;

endmodule

// ----- rtl/core/sialu_div_step.sv -----
// One restoring division step: produces one quotient bit per stage.
// Depends on sialu_pkg.
module sialu_div_step
    import sialu_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_adv,
    input  logic  i_valid,
    input  t_pipe i_pipe,
    output logic  o_valid,
    output t_pipe o_pipe
);

    logic        r_valid;
    t_pipe       r_pipe;
    t_pipe       n_pipe;
    logic [32:0] w_trial;
    logic [32:0] w_diff;
    logic        w_take;

    // Shift the next dividend bit into the remainder and try the subtraction.
    assign w_trial = {i_pipe.rem, i_pipe.quo[31]};
    assign w_diff  = w_trial - {1'b0, i_pipe.divisor};
    assign w_take  = ~w_diff[32];

    always_comb begin
        n_pipe     = i_pipe;
        n_pipe.rem = w_take ? w_diff[31:0] : w_trial[31:0];
        n_pipe.quo = {i_pipe.quo[30:0], w_take};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_pipe <= n_pipe;
        end
    end

    assign o_valid = r_valid;
    assign o_pipe  = r_pipe;

endmodule

// ----- rtl/core/signed_integer_alu_with_divide.sv -----
// Signed 32-bit ALU: add, subtract, multiply, divide and modulo.
// An accepted transaction passes through decode, multiply,
// 32 restoring divider stages (one quotient bit each) and the output register.
// Throughput is one transaction per cycle; the whole pipeline holds while the output stalls.
// Reset clears only the stage valid bits; no payload is reset.
module signed_integer_alu_with_divide
    import sialu_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_stall,
    input  t_alu_in  i_in_data,
    output logic     o_out_valid,
    input  logic     i_out_stall,
    output t_alu_out o_out_data
);

    logic     w_adv;
    logic     w_dec_valid;
    t_pipe    w_dec_pipe;
    logic     w_valid [0:DIV_STEPS];
    t_pipe    w_pipe  [0:DIV_STEPS];
    t_alu_out n_out;
    t_alu_out r_out;
    logic     r_out_valid;
    logic [31:0] w_quo;
    logic [31:0] w_rem;
    logic [31:0] w_prod;

    // The pipeline moves whenever the output register is free or being taken.
    assign w_adv      = ~(r_out_valid & i_out_stall);
    assign o_in_stall = ~w_adv;

    sialu_decode u_decode (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_valid (i_in_valid),
        .i_data  (i_in_data),
        .o_valid (w_dec_valid),
        .o_pipe  (w_dec_pipe)
    );

    sialu_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_valid (w_dec_valid),
        .i_pipe  (w_dec_pipe),
        .o_valid (w_valid[0]),
        .o_pipe  (w_pipe[0])
    );

    // Divider chain, one quotient bit per stage.
    for (genvar g = 0; g < DIV_STEPS; g++) begin : g_div
        sialu_div_step u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (w_adv),
            .i_valid (w_valid[g]),
            .i_pipe  (w_pipe[g]),
            .o_valid (w_valid[g+1]),
            .o_pipe  (w_pipe[g+1])
        );
    end

    // Restore signs and select the result; errors give zero.
    assign w_quo  = w_pipe[DIV_STEPS].neg_q ? (32'd0 - w_pipe[DIV_STEPS].quo)
                                            : w_pipe[DIV_STEPS].quo;
    assign w_rem  = w_pipe[DIV_STEPS].neg_r ? (32'd0 - w_pipe[DIV_STEPS].rem)
                                            : w_pipe[DIV_STEPS].rem;
    assign w_prod = w_pipe[DIV_STEPS].neg_q ? (32'd0 - w_pipe[DIV_STEPS].arith)
                                            : w_pipe[DIV_STEPS].arith;

    always_comb begin
        n_out.status = w_pipe[DIV_STEPS].status;
        n_out.result = '0;
        if (w_pipe[DIV_STEPS].status == ST_OK) begin
            case (w_pipe[DIV_STEPS].op)
                OP_ADD:  n_out.result = w_pipe[DIV_STEPS].arith;
                OP_SUB:  n_out.result = w_pipe[DIV_STEPS].arith;
                OP_MUL:  n_out.result = w_prod;
                OP_DIV:  n_out.result = w_quo;
                OP_MOD:  n_out.result = w_rem;
                default: n_out.result = '0;
            endcase
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= w_valid[DIV_STEPS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// ----- sim/tb.sv -----
// Self-checking testbench for the signed 32-bit ALU with divide and modulo.
// Depends on sialu_pkg and signed_integer_alu_with_divide; it reads no files.
`timescale 1ns / 1ps

module tb;
    import sialu_pkg::*;

    localparam int  RANDOM_ITEMS = 600;
    localparam int  DRAIN_CYCLES = 40;
    localparam time TIMEOUT_NS   = 2_000_000;

    // One row of the directed table: the command, and a typed-in result where one is given.
    typedef struct {
        t_alu_in  item;
        logic     fixed;
        t_alu_out want;
    } t_alu_row;

    logic     i_clk       = 1'b0;
    logic     i_rst_n     = 1'b0;
    logic     i_in_valid  = 1'b0;
    t_alu_in  i_in_data   = '0;
    logic     i_out_stall = 1'b0;
    logic     o_in_stall;
    logic     o_out_valid;
    t_alu_out o_out_data;

    // Travels with each driven transaction: whether its result is typed in, and that result.
    logic     drive_fixed = 1'b0;
    t_alu_out drive_want  = '0;

    int       in_idle_pct  = 24;
    int       out_stall_pct = 77;
    int       error_count  = 0;

    t_alu_out pending_results[$];
    t_alu_row directed_rows[$];

    signed_integer_alu_with_divide uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    always #4 i_clk = ~i_clk;

    // The receiver stalls at random, at the rate of the current phase.
    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < out_stall_pct);
    end

    // Works out the result of one ALU transaction.
    function automatic t_alu_out alu_result(t_alu_in item);
        logic [31:0] lhs;
        logic [31:0] rhs;
        logic [31:0] mag_lhs;
        logic [31:0] mag_rhs;
        logic [31:0] quotient;
        logic [31:0] remainder;
        logic [63:0] product;
        t_alu_out    res;
        lhs        = item.operand_a;
        rhs        = item.operand_b;
        mag_lhs    = lhs[31] ? (~lhs + 32'd1) : lhs;
        mag_rhs    = rhs[31] ? (~rhs + 32'd1) : rhs;
        res.result = '0;
        res.status = ST_OK;
        case (item.cmd)
            CMD_ADD: begin
                res.result = lhs + rhs;
            end
            CMD_SUB: begin
                res.result = lhs - rhs;
            end
            CMD_MUL: begin
                product    = {32'd0, lhs} * {32'd0, rhs};
                res.result = product[31:0];
            end
            CMD_DIV: begin
                if (rhs == 32'd0) begin
                    res.status = ST_DIV_ZERO;
                end else begin
                    // Truncating quotient: divide magnitudes, then apply the sign.
                    quotient   = mag_lhs / mag_rhs;
                    res.result = (lhs[31] ^ rhs[31]) ? (~quotient + 32'd1) : quotient;
                end
            end
            CMD_MOD: begin
                if (rhs == 32'd0) begin
                    res.status = ST_MOD_ZERO;
                end else begin
                    // The remainder follows the sign of the dividend.
                    remainder  = mag_lhs % mag_rhs;
                    res.result = lhs[31] ? (~remainder + 32'd1) : remainder;
                end
            end
            default: begin
                res.status = ST_BAD_OP;
            end
        endcase
        return res;
    endfunction

    // Operands lean towards the edges: zero, one, minus one and the extremes.
    function automatic logic [31:0] pick_operand();
        logic [31:0] value;
        case ($urandom_range(9))
            0, 1, 2, 3: value = $urandom;
            4, 5:       value = $urandom_range(200) - 100;
            6: begin
                case ($urandom_range(4))
                    0: value = 32'h8000_0000;
                    1: value = 32'h7FFF_FFFF;
                    2: value = 32'hFFFF_FFFF;
                    3: value = 32'd1;
                    default: value = 32'd0;
                endcase
            end
            7:       value = 32'd1 << $urandom_range(31);
            8:       value = $urandom_range(65535);
            default: value = -($urandom_range(65535));
        endcase
        return value;
    endfunction

    task automatic add_row(input logic [7:0] cmd, input logic [31:0] lhs,
                           input logic [31:0] rhs, input logic fixed,
                           input logic [31:0] result, input logic [1:0] status);
        t_alu_row row;
        row.item.cmd       = cmd;
        row.item.operand_a = lhs;
        row.item.operand_b = rhs;
        row.fixed          = fixed;
        row.want.result    = result;
        row.want.status    = status;
        directed_rows.push_back(row);
    endtask

    // Offers one transaction, with a random number of idle cycles first.
    task automatic send_item(input t_alu_in item, input logic fixed, input t_alu_out want);
        while ($urandom_range(99) < in_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_in_data   <= item;
        drive_fixed <= fixed;
        drive_want  <= want;
        @(posedge i_clk);
        while (o_in_stall) begin
            @(posedge i_clk);
        end
    endtask

    // Records the expected result of each accepted transaction and checks each result.
    always @(posedge i_clk) begin : result_check
        t_alu_out want;
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                if (drive_fixed) begin
                    pending_results.push_back(drive_want);
                end else begin
                    pending_results.push_back(alu_result(i_in_data));
                end
            end
            if (o_out_valid && !i_out_stall) begin
                if (pending_results.size() == 0) begin
                    error_count++;
                    $display("%0t: unexpected result: expected none, actual result %0d status %0d",
                             $time, o_out_data.result, o_out_data.status);
                end else begin
                    want = pending_results.pop_front();
                    if (o_out_data.result !== want.result) begin
                        error_count++;
                        $display("%0t: result mismatch: expected %0d, actual %0d",
                                 $time, want.result, o_out_data.result);
                    end
                    if (o_out_data.status !== want.status) begin
                        error_count++;
                        $display("%0t: status mismatch: expected %0d, actual %0d",
                                 $time, want.status, o_out_data.status);
                    end
                end
            end
        end
    end

    // Directed table, then random transactions, across three idling phases.
    initial begin : stimulus
        t_alu_in  item;
        t_alu_out want;
        int       total;
        int       drain;

        // Wrap-around, most negative by minus one, zero divisors and unknown operators.
        add_row(CMD_ADD, 32'h7FFF_FFFF, 32'd1,         1'b1, 32'h8000_0000, ST_OK);
        add_row(CMD_ADD, 32'h8000_0000, 32'h8000_0000, 1'b1, 32'd0,         ST_OK);
        add_row(CMD_SUB, 32'h8000_0000, 32'd1,         1'b1, 32'h7FFF_FFFF, ST_OK);
        add_row(CMD_SUB, 32'd0,         32'h8000_0000, 1'b1, 32'h8000_0000, ST_OK);
        add_row(CMD_MUL, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1, 32'd1,         ST_OK);
        add_row(CMD_MUL, 32'h8000_0000, 32'hFFFF_FFFF, 1'b1, 32'h8000_0000, ST_OK);
        add_row(CMD_DIV, 32'h8000_0000, 32'hFFFF_FFFF, 1'b1, 32'h8000_0000, ST_OK);
        add_row(CMD_MOD, 32'h8000_0000, 32'hFFFF_FFFF, 1'b1, 32'd0,         ST_OK);
        add_row(CMD_DIV, 32'd5,         32'd0,         1'b1, 32'd0,         ST_DIV_ZERO);
        add_row(CMD_DIV, 32'h8000_0000, 32'd0,         1'b1, 32'd0,         ST_DIV_ZERO);
        add_row(CMD_MOD, 32'hFFFF_FFFB, 32'd0,         1'b1, 32'd0,         ST_MOD_ZERO);
        add_row(CMD_MOD, 32'h7FFF_FFFF, 32'd0,         1'b1, 32'd0,         ST_MOD_ZERO);
        // Unknown operators: NUL, all ones and a neighbour of the known characters.
        add_row(8'h00,   32'd7,         32'd3,         1'b1, 32'd0,         ST_BAD_OP);
        add_row(8'hFF,   32'hFFFF_FFFF, 32'd0,         1'b1, 32'd0,         ST_BAD_OP);
        add_row(8'h2E,   32'd9,         32'd9,         1'b1, 32'd0,         ST_BAD_OP);
        // Sign handling of divide and modulo, and ordinary arithmetic.
        add_row(CMD_DIV, 32'hFFFF_FFF9, 32'd2,         1'b0, 32'd0,         ST_OK);
        add_row(CMD_DIV, 32'd7,         32'hFFFF_FFFE, 1'b0, 32'd0,         ST_OK);
        add_row(CMD_DIV, 32'h8000_0000, 32'h8000_0000, 1'b0, 32'd0,         ST_OK);
        add_row(CMD_DIV, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0, 32'd0,         ST_OK);
        add_row(CMD_MOD, 32'hFFFF_FFF9, 32'd2,         1'b0, 32'd0,         ST_OK);
        add_row(CMD_MOD, 32'd7,         32'hFFFF_FFFE, 1'b0, 32'd0,         ST_OK);
        add_row(CMD_MOD, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0, 32'd0,         ST_OK);
        add_row(CMD_MUL, 32'h1234_5678, 32'h09AB_CDEF, 1'b0, 32'd0,         ST_OK);
        add_row(CMD_MUL, 32'hFFFF_FFFD, 32'd7,         1'b0, 32'd0,         ST_OK);
        add_row(CMD_SUB, 32'd5,         32'd9,         1'b0, 32'd0,         ST_OK);

        total = directed_rows.size() + RANDOM_ITEMS;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int idx = 0; idx < total; idx++) begin
            // Thirds of the run: sender idles less, then more, then neither side idles.
            case (idx * 3 / total)
                0: begin
                    in_idle_pct   = 24;
                    out_stall_pct = 77;
                end
                1: begin
                    in_idle_pct   = 77;
                    out_stall_pct = 24;
                end
                default: begin
                    in_idle_pct   = 0;
                    out_stall_pct = 0;
                end
            endcase
            if (idx < directed_rows.size()) begin
                send_item(directed_rows[idx].item, directed_rows[idx].fixed,
                          directed_rows[idx].want);
            end else begin
                case ($urandom_range(11))
                    0, 1: item.cmd = CMD_ADD;
                    2, 3: item.cmd = CMD_SUB;
                    4, 5: item.cmd = CMD_MUL;
                    6, 7: item.cmd = CMD_DIV;
                    8, 9: item.cmd = CMD_MOD;
                    default: begin
                        item.cmd = 8'($urandom_range(255));
                        while (item.cmd == CMD_ADD || item.cmd == CMD_SUB ||
                               item.cmd == CMD_MUL || item.cmd == CMD_DIV ||
                               item.cmd == CMD_MOD) begin
                            item.cmd = 8'($urandom_range(255));
                        end
                    end
                endcase
                item.operand_a = pick_operand();
                item.operand_b = pick_operand();
                want = '0;
                send_item(item, 1'b0, want);
            end
        end
        i_in_valid <= 1'b0;

        while (pending_results.size() != 0) begin
            @(posedge i_clk);
        end
        // Give any stray result time to appear.
        for (drain = 0; drain < DRAIN_CYCLES; drain++) begin
            @(posedge i_clk);
        end

        if (error_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // Hard limit on the length of the run.
    initial begin
        #(TIMEOUT_NS);
        $display("status: fail");
        $finish;
    end

endmodule
